/* design/hdc_pkg.sv */
`default_nettype none

package hdc_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CODE_W  = 5;
    localparam int DOY_W   = 9;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_HOLIDAY_YEAR = 1'b0;
    localparam logic [YEAR_W-1:0] HOLIDAY_YEAR_RESET = 14'd2000;

    // Pipeline depth from query acceptance to result register
    localparam int PIPE_DEPTH = 12;

    typedef logic [CODE_W-1:0] code_t;

    // Holiday codes in listing order
    localparam code_t CODE_NEW_YEAR        = 5'd0;
    localparam code_t CODE_EPIPHANY        = 5'd1;
    localparam code_t CODE_GOOD_FRIDAY     = 5'd2;
    localparam code_t CODE_EASTER_SUNDAY   = 5'd3;
    localparam code_t CODE_EASTER_MONDAY   = 5'd4;
    localparam code_t CODE_LABOUR_DAY      = 5'd5;
    localparam code_t CODE_ASCENSION       = 5'd6;
    localparam code_t CODE_PENTECOST_SUN   = 5'd7;
    localparam code_t CODE_PENTECOST_MON   = 5'd8;
    localparam code_t CODE_CORPUS_CHRISTI  = 5'd9;
    localparam code_t CODE_ASSUMPTION      = 5'd10;
    localparam code_t CODE_NATIONAL_DAY    = 5'd11;
    localparam code_t CODE_ALL_SAINTS      = 5'd12;
    localparam code_t CODE_FIRST_ADVENT    = 5'd13;
    localparam code_t CODE_IMMACULATE      = 5'd14;
    localparam code_t CODE_CHRISTMAS       = 5'd15;
    localparam code_t CODE_BOXING_DAY      = 5'd16;
    localparam code_t CODE_NEW_YEARS_EVE   = 5'd17;
    localparam code_t CODE_NONE            = 5'd18;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Reciprocals for division by constants; each is exact over its input range
    localparam logic [14:0] RECIP_19  = 15'd27595;  // shift 19, y up to 16383
    localparam logic [12:0] RECIP_100 = 13'd5243;   // shift 19, y up to 16383
    localparam logic [15:0] RECIP_7W  = 16'd37450;  // shift 18, sum up to 20507
    localparam logic [10:0] RECIP_30  = 11'd1093;   // shift 15, up to 1023
    localparam logic [7:0]  RECIP_7L  = 8'd147;     // shift 10, up to 127

    // Day of year of Nov 27 in a common year, and Easter offset (s - 33)
    localparam logic [DOY_W-1:0] ADVENT_BASE = 9'd331;
    localparam logic [DOY_W-1:0] EASTER_BASE = 9'd81;
    localparam logic [9:0]       COMPUTUS_M_LIMIT = 10'd451;

    // Everything that travels down the pipeline
    typedef struct packed {
        logic                year_eq;
        logic                date_ok;
        logic                leap;
        logic                m;
        logic [MONTH_W-1:0]  qm;
        logic [DAY_W-1:0]    qd;
        logic [YEAR_W-1:0]   y;
        logic [9:0]          q19;
        logic [7:0]          b;
        logic [4:0]          a;
        logic [6:0]          c;
        logic [14:0]         wsum;
        logic [2:0]          f;
        logic [5:0]          g;
        logic [11:0]         w7q;
        logic [2:0]          wmod;
        logic [9:0]          hsum;
        logic [5:0]          hq;
        logic [4:0]          h;
        logic [6:0]          lsum;
        logic [3:0]          lq;
        logic [2:0]          l;
        logic [DOY_W-1:0]    qdoy;
        logic [DOY_W-1:0]    adv;
        logic [DOY_W-1:0]    es;
        code_t               code;
    } pipe_t;

    // Days before the first of the month in a common year
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon);
        logic [DOY_W-1:0] r;
        unique case (mon)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Length of the month in a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon);
        logic [DAY_W-1:0] r;
        unique case (mon)
            4'd2:                       r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
            default:                    r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic on_date(
        input logic [MONTH_W-1:0] qm,
        input logic [DAY_W-1:0]   qd,
        input logic [MONTH_W-1:0] mon,
        input logic [DAY_W-1:0]   day
    );
        return (qm == mon) && (qd == day);
    endfunction

endpackage

`default_nettype wire

/* design/hdc_if.sv */
`default_nettype none

// Query channel: one date per word
interface hdc_query_if;
    logic                          valid;
    logic                          ready;
    logic [hdc_pkg::YEAR_W-1:0]    query_year;
    logic [hdc_pkg::MONTH_W-1:0]   query_month;
    logic [hdc_pkg::DAY_W-1:0]     query_day;

    modport source (output valid, output query_year, output query_month,
                    output query_day, input ready);
    modport sink   (input valid, input query_year, input query_month,
                    input query_day, output ready);
endinterface

// Result channel: one classification per word
interface hdc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          is_holiday;
    logic [hdc_pkg::CODE_W-1:0]    holiday_code;

    modport source (output valid, output is_holiday, output holiday_code, input ready);
    modport sink   (input valid, input is_holiday, input holiday_code, output ready);
endinterface

`default_nettype wire

/* design/holiday_date_classifier.sv */
`default_nettype none
// Path: an accepted query enters stage 0 and moves on through stages 1 to 11;
// result valid is the valid bit of stage 11.
// Throughput: one query per cycle unless result back-pressure stalls; each of the
// twelve stages is at most one constant-reciprocal multiply deep.
// Stages advance independently, so bubbles collapse under result back-pressure.
// Reset: clears all stage valid bits and sets holiday_year to 2000; data is not reset.

module holiday_date_classifier (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    hdc_query_if.sink                         query,
    hdc_result_if.source                      result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hdc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [hdc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [hdc_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int NSTG = hdc_pkg::PIPE_DEPTH;

    logic [hdc_pkg::YEAR_W-1:0] holiday_year_reg;
    logic [hdc_pkg::YEAR_W-1:0] holiday_year_next;
    logic                       cfg_write;

    hdc_pkg::pipe_t             stg_reg  [NSTG];
    hdc_pkg::pipe_t             stg_next [NSTG];
    logic [NSTG-1:0]            stg_valid_reg;
    logic [NSTG-1:0]            stg_valid_next;
    logic [NSTG:0]              stg_ready;

    // Configuration register write and read back
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == hdc_pkg::REG_IDX_HOLIDAY_YEAR);
    assign holiday_year_next = cfg_write ? pwdata[hdc_pkg::YEAR_W-1:0] : holiday_year_reg;
    assign prdata = (paddr[2] == hdc_pkg::REG_IDX_HOLIDAY_YEAR)
                    ? hdc_pkg::PDATA_W'(holiday_year_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holiday_year_reg <= hdc_pkg::HOLIDAY_YEAR_RESET;
        end
        else
        begin
            holiday_year_reg <= holiday_year_next;
        end
    end

    // Stage handshake: a stage loads when empty or when its word moves on
    assign stg_ready[NSTG] = result.ready;

    genvar gk;
    generate
        for (gk = 0; gk < NSTG; gk++)
        begin : g_ready
            assign stg_ready[gk] = !stg_valid_reg[gk] || stg_ready[gk+1];
        end
    endgenerate

    assign query.ready = stg_ready[0];

    always_comb
    begin
        stg_valid_next[0] = stg_ready[0] ? query.valid : stg_valid_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            stg_valid_next[k] = stg_ready[k] ? stg_valid_reg[k-1] : stg_valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (stg_ready[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // Stage datapath
    always_comb
    begin : stage_logic
        logic [28:0]  prod19;
        logic [26:0]  prod100;
        logic [13:0]  a_full;
        logic [13:0]  c_full;
        logic [7:0]   fnum;
        logic [13:0]  fprod;
        logic [7:0]   gnum;
        logic [15:0]  gprod;
        logic [30:0]  wprod;
        logic [4:0]   lim;
        logic [14:0]  wrem;
        logic [20:0]  hprod;
        logic [9:0]   hrem;
        logic [14:0]  lprod;
        logic [6:0]   lrem;
        logic [9:0]   mx;
        hdc_pkg::pipe_t s;
        hdc_pkg::code_t code;

        // Stage 0: capture query and year, take y/19 and y/100
        stg_next[0]         = '0;
        stg_next[0].y       = holiday_year_reg;
        stg_next[0].qm      = query.query_month;
        stg_next[0].qd      = query.query_day;
        stg_next[0].year_eq = (query.query_year == holiday_year_reg);
        prod19  = 29'(holiday_year_reg) * 29'(hdc_pkg::RECIP_19);
        prod100 = 27'(holiday_year_reg) * 27'(hdc_pkg::RECIP_100);
        stg_next[0].q19 = prod19[28:19];
        stg_next[0].b   = prod100[26:19];

        // Stage 1: remainders, leap year, weekday sum, f = (b+8)/25
        s = stg_reg[0];
        a_full = s.y - 14'(s.q19) * 14'd19;
        c_full = s.y - 14'(s.b) * 14'd100;
        s.a    = a_full[4:0];
        s.c    = c_full[6:0];
        s.leap = (s.y[1:0] == 2'd0) && ((c_full[6:0] != 7'd0) || (s.b[1:0] == 2'd0));
        s.wsum = 15'(s.y) + 15'(s.y >> 2) - 15'(s.b) + 15'(s.b >> 2) + 15'd29;
        fnum   = s.b + 8'd8;
        fprod  = 14'(fnum) * 14'd41;
        s.f    = fprod[12:10];
        stg_next[1] = s;

        // Stage 2: g = (b-f+1)/3, weekday quotient, date check and query day of year
        s = stg_reg[1];
        gnum   = s.b - 8'(s.f) + 8'd1;
        gprod  = 16'(gnum) * 16'd171;
        s.g    = gprod[14:9];
        wprod  = 31'(s.wsum) * 31'(hdc_pkg::RECIP_7W);
        s.w7q  = wprod[29:18];
        lim    = hdc_pkg::month_len(s.qm) + 5'((s.qm == hdc_pkg::MONTH_FEB) && s.leap);
        s.date_ok = (s.qm >= hdc_pkg::MONTH_JAN) && (s.qm <= hdc_pkg::MONTH_DEC)
                    && (s.qd != 5'd0) && (s.qd <= lim);
        s.qdoy = hdc_pkg::month_start(s.qm) + 9'(s.qd)
                 + 9'((s.qm > hdc_pkg::MONTH_FEB) && s.leap);
        stg_next[2] = s;

        // Stage 3: weekday of Nov 27, epact sum before mod 30
        s = stg_reg[2];
        wrem   = s.wsum - 15'(s.w7q) * 15'd7;
        s.wmod = wrem[2:0];
        s.hsum = 10'(s.a) * 10'd19 + 10'(s.b) - 10'(s.b >> 2) - 10'(s.g) + 10'd15;
        stg_next[3] = s;

        // Stage 4: quotient by 30, First Advent day of year
        s = stg_reg[3];
        hprod = 21'(s.hsum) * 21'(hdc_pkg::RECIP_30);
        s.hq  = hprod[20:15];
        s.adv = hdc_pkg::ADVENT_BASE + 9'(s.leap)
                + ((s.wmod == 3'd0) ? 9'd0 : (9'd7 - 9'(s.wmod)));
        stg_next[4] = s;

        // Stage 5: h = hsum mod 30
        s = stg_reg[4];
        hrem = s.hsum - 10'(s.hq) * 10'd30;
        s.h  = hrem[4:0];
        stg_next[5] = s;

        // Stage 6: weekday correction sum before mod 7
        s = stg_reg[5];
        s.lsum = 7'd32 + 7'(s.b[1:0]) * 7'd2 + 7'(s.c[6:2]) * 7'd2
                 - 7'(s.h) - 7'(s.c[1:0]);
        stg_next[6] = s;

        // Stage 7: quotient by 7
        s = stg_reg[6];
        lprod = 15'(s.lsum) * 15'(hdc_pkg::RECIP_7L);
        s.lq  = lprod[13:10];
        stg_next[7] = s;

        // Stage 8: l = lsum mod 7
        s = stg_reg[7];
        lrem = s.lsum - 7'(s.lq) * 7'd7;
        s.l  = lrem[2:0];
        stg_next[8] = s;

        // Stage 9: late-April correction flag
        s = stg_reg[8];
        mx  = 10'(s.a) + 10'(s.h) * 10'd11 + 10'(s.l) * 10'd22;
        s.m = (mx >= hdc_pkg::COMPUTUS_M_LIMIT);
        stg_next[9] = s;

        // Stage 10: Easter Sunday day of year
        s = stg_reg[9];
        s.es = 9'(s.h) + 9'(s.l) + hdc_pkg::EASTER_BASE + 9'(s.leap)
               - (s.m ? 9'd7 : 9'd0);
        stg_next[10] = s;

        // Stage 11: match against the holiday list, later entries win
        s = stg_reg[10];
        code = hdc_pkg::CODE_NONE;
        if (s.year_eq && s.date_ok)
        begin
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd1, 5'd1))
                code = hdc_pkg::CODE_NEW_YEAR;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd1, 5'd6))
                code = hdc_pkg::CODE_EPIPHANY;
            if (s.qdoy == s.es - 9'd2)
                code = hdc_pkg::CODE_GOOD_FRIDAY;
            if (s.qdoy == s.es)
                code = hdc_pkg::CODE_EASTER_SUNDAY;
            if (s.qdoy == s.es + 9'd1)
                code = hdc_pkg::CODE_EASTER_MONDAY;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd5, 5'd1))
                code = hdc_pkg::CODE_LABOUR_DAY;
            if (s.qdoy == s.es + 9'd39)
                code = hdc_pkg::CODE_ASCENSION;
            if (s.qdoy == s.es + 9'd49)
                code = hdc_pkg::CODE_PENTECOST_SUN;
            if (s.qdoy == s.es + 9'd50)
                code = hdc_pkg::CODE_PENTECOST_MON;
            if (s.qdoy == s.es + 9'd60)
                code = hdc_pkg::CODE_CORPUS_CHRISTI;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd8, 5'd15))
                code = hdc_pkg::CODE_ASSUMPTION;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd10, 5'd26))
                code = hdc_pkg::CODE_NATIONAL_DAY;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd11, 5'd1))
                code = hdc_pkg::CODE_ALL_SAINTS;
            if (s.qdoy == s.adv)
                code = hdc_pkg::CODE_FIRST_ADVENT;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd12, 5'd8))
                code = hdc_pkg::CODE_IMMACULATE;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd12, 5'd25))
                code = hdc_pkg::CODE_CHRISTMAS;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd12, 5'd26))
                code = hdc_pkg::CODE_BOXING_DAY;
            if (hdc_pkg::on_date(s.qm, s.qd, 4'd12, 5'd31))
                code = hdc_pkg::CODE_NEW_YEARS_EVE;
        end
        s.code = code;
        stg_next[11] = s;
    end

    // Result word from the last stage
    assign result.valid        = stg_valid_reg[NSTG-1];
    assign result.holiday_code = stg_reg[NSTG-1].code;
    assign result.is_holiday   = (stg_reg[NSTG-1].code != hdc_pkg::CODE_NONE);

`ifndef SYNTHESIS
    // Remainders by 30 and 7 stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg[8] |-> (stg_reg[8].h < 5'd30) && (stg_reg[8].l < 3'd7))
    else $error("computus remainder out of range");

    // First Advent lands between Nov 27 and Dec 3
    assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg[4] |-> (stg_reg[4].adv >= hdc_pkg::ADVENT_BASE)
                             && (stg_reg[4].adv <= hdc_pkg::ADVENT_BASE + 9'd7))
    else $error("advent day of year out of range");

    // Easter Sunday lands between Mar 22 and Apr 25
    assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg[10] |-> (stg_reg[10].es >= 9'd81) && (stg_reg[10].es <= 9'd116))
    else $error("easter day of year out of range");

    // A holiday needs a matching year and a real date
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.is_holiday |->
            stg_reg[NSTG-1].year_eq && stg_reg[NSTG-1].date_ok
            && (result.holiday_code < hdc_pkg::CODE_NONE))
    else $error("holiday reported for a rejected query");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
    import hdc_pkg::*;

    localparam int NUM_YEARS       = 13;
    localparam int DATES_PER_YEAR  = 46;
    localparam int TIMEOUT_CYCLES  = 400000;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_query_t;

    typedef struct packed {
        logic  is_holiday;
        code_t code;
    } day_class_t;

    typedef int unsigned holiday_days_t [CODE_NONE];

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port, driven from the sequence below
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Query and result channels
    hdc_query_if  query_ch ();
    hdc_result_if result_ch ();

    logic        offer_valid = 1'b0;
    date_query_t offer = '0;
    logic        take_ready = 1'b0;

    assign query_ch.valid       = offer_valid;
    assign query_ch.query_year  = offer.year;
    assign query_ch.query_month = offer.month;
    assign query_ch.query_day   = offer.day;
    assign result_ch.ready      = take_ready;

    // Stimulus and prediction stores
    date_query_t        pending_dates [$];
    day_class_t         predicted_classes [$];
    logic [YEAR_W-1:0]  cfg_year = HOLIDAY_YEAR_RESET;

    int unsigned error_count = 0;
    int unsigned queries_sent = 0;
    int unsigned results_checked = 0;
    int unsigned holidays_flagged = 0;
    logic [31:0] codes_seen = '0;

    holiday_date_classifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic int unsigned is_leap(input int unsigned y);
        return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 1 : 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            MONTH_FEB:   return 28 + is_leap(y);
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // 1-based day of year; month must be in 1..12
    function automatic int unsigned day_of_year(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned n;
        n = d;
        for (int k = 1; k < m; k++)
            n += month_length(y, k);
        return n;
    endfunction

    function automatic void date_of_day(input int unsigned y, input int unsigned doy,
                                        output int unsigned m, output int unsigned d);
        m = 1;
        d = doy;
        while (m < 12 && d > month_length(y, m))
        begin
            d -= month_length(y, m);
            m++;
        end
    endfunction

    function automatic date_query_t date_word(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
        date_query_t w;
        w.year  = YEAR_W'(y);
        w.month = MONTH_W'(m);
        w.day   = DAY_W'(d);
        return w;
    endfunction

    // Day of year of every holiday of year y, indexed by holiday code
    function automatic holiday_days_t holiday_days(input int unsigned y);
        holiday_days_t tab;
        int unsigned   a, b, c, e, f, g, h, k, l, m, s;
        int unsigned   easter_mon, easter_dom, easter, wd;
        // anonymous Gregorian computus
        a = y % 19;
        b = y / 100;
        c = y % 100;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - b / 4 - g + 15) % 30;
        k = c % 4;
        l = (32 + 2 * e + 2 * (c / 4) - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        s = h + l - 7 * m + 114;
        easter_mon = s / 31;
        easter_dom = s % 31 + 1;
        if (easter_mon < 1 || easter_mon > 12)
            easter_mon = 3;
        easter = day_of_year(y, easter_mon, easter_dom);
        // weekday of Nov 27, Monday 1 .. Sunday 7; 2 is the November month offset
        wd = (y + y / 4 - y / 100 + y / 400 + 2 + 27) % 7;
        if (wd == 0)
            wd = 7;
        tab[CODE_NEW_YEAR]       = day_of_year(y, 1, 1);
        tab[CODE_EPIPHANY]       = day_of_year(y, 1, 6);
        tab[CODE_GOOD_FRIDAY]    = easter - 2;
        tab[CODE_EASTER_SUNDAY]  = easter;
        tab[CODE_EASTER_MONDAY]  = easter + 1;
        tab[CODE_LABOUR_DAY]     = day_of_year(y, 5, 1);
        tab[CODE_ASCENSION]      = easter + 39;
        tab[CODE_PENTECOST_SUN]  = easter + 49;
        tab[CODE_PENTECOST_MON]  = easter + 50;
        tab[CODE_CORPUS_CHRISTI] = easter + 60;
        tab[CODE_ASSUMPTION]     = day_of_year(y, 8, 15);
        tab[CODE_NATIONAL_DAY]   = day_of_year(y, 10, 26);
        tab[CODE_ALL_SAINTS]     = day_of_year(y, 11, 1);
        tab[CODE_FIRST_ADVENT]   = day_of_year(y, 11, 27) + 7 - wd;
        tab[CODE_IMMACULATE]     = day_of_year(y, 12, 8);
        tab[CODE_CHRISTMAS]      = day_of_year(y, 12, 25);
        tab[CODE_BOXING_DAY]     = day_of_year(y, 12, 26);
        tab[CODE_NEW_YEARS_EVE]  = day_of_year(y, 12, 31);
        return tab;
    endfunction

    // Classify one date against the holidays of the configured year
    function automatic day_class_t classify_date(input logic [YEAR_W-1:0] hy,
                                                 input date_query_t qry);
        day_class_t    res;
        holiday_days_t days;
        int unsigned   qdoy;
        res.is_holiday = 1'b0;
        res.code       = CODE_NONE;
        if (qry.year != hy || qry.month < MONTH_JAN || qry.month > MONTH_DEC || qry.day == '0)
            return res;
        if (qry.day > month_length(qry.year, qry.month))
            return res;
        qdoy = day_of_year(qry.year, qry.month, qry.day);
        days = holiday_days(hy);
        // later codes overwrite earlier ones on a shared date
        for (int i = 0; i < CODE_NONE; i++)
        begin
            if (days[i] == qdoy)
            begin
                res.is_holiday = 1'b1;
                res.code       = code_t'(i);
            end
        end
        return res;
    endfunction

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Sender: bursts of words with random gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offer_valid <= 1'b0;
            offer       <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // predict each accepted word
            if (offer_valid && query_ch.ready)
            begin
                predicted_classes.push_back(classify_date(cfg_year, offer));
                queries_sent++;
            end
            // advance only when the current word is gone or none is offered
            if (!offer_valid || query_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    offer_valid <= 1'b0;
                end
                else if (pending_dates.size() > 0)
                begin
                    offer       <= pending_dates.pop_front();
                    offer_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    offer_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern plus a few long hold-offs
    rx_mode_t    rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned holds_done;
    day_class_t  want;
    logic        next_ready;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            rx_mode    = RX_STREAM;
            mode_left  = 0;
            hold_left  = 0;
            holds_done = 0;
        end
        else
        begin
            // check each accepted result word
            if (result_ch.valid && take_ready)
            begin
                if (predicted_classes.size() == 0)
                begin
                    $error("result word with no prediction pending: is_holiday %0d code %0d",
                           result_ch.is_holiday, result_ch.holiday_code);
                    error_count++;
                end
                else
                begin
                    want = predicted_classes.pop_front();
                    if (result_ch.is_holiday !== want.is_holiday)
                    begin
                        $error("is_holiday: expected %0d, got %0d",
                               want.is_holiday, result_ch.is_holiday);
                        error_count++;
                    end
                    if (result_ch.holiday_code !== want.code)
                    begin
                        $error("holiday_code: expected %0d, got %0d",
                               want.code, result_ch.holiday_code);
                        error_count++;
                    end
                    results_checked++;
                    if (want.is_holiday)
                        holidays_flagged++;
                    codes_seen[want.code] = 1'b1;
                end
            end
            // pick readiness for the next cycle
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (holds_done < 3 && pending_dates.size() > 30
                     && results_checked > 150 * holds_done)
            begin
                hold_left  = $urandom_range(60, 100);
                holds_done++;
                next_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(2));
                    mode_left = $urandom_range(10, 60);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_STREAM: next_ready = 1'b1;
                    RX_RANDOM: next_ready = 1'($urandom_range(1));
                    default:   next_ready = ($urandom_range(3) == 0);
                endcase
            end
            take_ready <= next_ready;
        end
    end

    // Sequence: reset, then one holiday year per group of queries
    initial
    begin
        int unsigned   phase_years [NUM_YEARS];
        holiday_days_t days;
        int unsigned   sel, mon, dd, qy;
        phase_years = '{2000, 2008, 2022, 0, 16383, 1583, 9999, 2285, 2038,
                         $urandom_range(1583, 9999), $urandom_range(1583, 9999),
                         $urandom_range(0, 16383), $urandom_range(0, 16383)};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_YEARS; ph++)
        begin
            // write the year register while the block is idle; the first group keeps reset
            if (ph > 0)
            begin
                @(posedge clk);
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= 1'b1;
                paddr   <= PADDR_W'(4 * int'(REG_IDX_HOLIDAY_YEAR));
                pwdata  <= PDATA_W'(phase_years[ph]);
                @(posedge clk);
                penable <= 1'b1;
                do
                    @(posedge clk);
                while (!pready);
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
                cfg_year = YEAR_W'(phase_years[ph]);
                @(negedge clk);
            end

            // directed dates
            days = holiday_days(cfg_year);
            case (ph)
                0:
                begin
                    for (int i = 0; i < CODE_NONE; i++)
                    begin
                        date_of_day(cfg_year, days[i], mon, dd);
                        pending_dates.push_back(date_word(cfg_year, mon, dd));
                    end
                    pending_dates.push_back(date_word(cfg_year - 1, 1, 1));
                    pending_dates.push_back(date_word(0, 1, 1));
                    pending_dates.push_back(date_word(16383, 15, 31));
                    pending_dates.push_back(date_word(cfg_year, 0, 1));
                    pending_dates.push_back(date_word(cfg_year, 13, 1));
                    pending_dates.push_back(date_word(cfg_year, 2, 0));
                    pending_dates.push_back(date_word(cfg_year, 2, 29));
                    pending_dates.push_back(date_word(cfg_year, 2, 30));
                    pending_dates.push_back(date_word(cfg_year, 4, 31));
                end
                // Ascension lands on Labour Day
                1: pending_dates.push_back(date_word(cfg_year, 5, 1));
                // Nov 27 is already a Sunday
                2: pending_dates.push_back(date_word(cfg_year, 11, 27));
                default: ;
            endcase

            // random dates, mostly in the configured year
            for (int n = 0; n < DATES_PER_YEAR; n++)
            begin
                sel = $urandom_range(99);
                qy  = cfg_year;
                if (sel < 40)
                begin
                    date_of_day(cfg_year, days[$urandom_range(CODE_NONE - 1)], mon, dd);
                end
                else if (sel < 70)
                begin
                    mon = $urandom_range(1, 12);
                    dd  = $urandom_range(1, month_length(qy, mon));
                end
                else if (sel < 78)
                begin
                    // around the end of a month
                    mon = $urandom_range(1, 12);
                    dd  = month_length(qy, mon) - 1 + $urandom_range(2);
                end
                else if (sel < 88)
                begin
                    qy  = ($urandom_range(1) == 0) ? $urandom_range(0, 16383)
                                                   : ((cfg_year + $urandom_range(1, 2)) % 16384);
                    mon = $urandom_range(1, 12);
                    dd  = $urandom_range(1, month_length(qy, mon));
                end
                else
                begin
                    qy  = ($urandom_range(1) == 0) ? cfg_year : $urandom_range(0, 16383);
                    mon = $urandom_range(0, 15);
                    dd  = $urandom_range(0, 31);
                end
                pending_dates.push_back(date_word(qy, mon, dd));
            end

            // drain before the next register write
            while (pending_dates.size() != 0 || offer_valid || predicted_classes.size() != 0)
                @(negedge clk);
        end

        repeat (PIPE_DEPTH + 8) @(negedge clk);
        $display("tb_top: %0d date queries checked against %0d holiday years", results_checked,
                 NUM_YEARS);
        $display("tb_top: %0d holidays flagged, %0d of %0d code values seen", holidays_flagged,
                 $countones(codes_seen), CODE_NONE + 1);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* holiday_date_classifier.f */
design/hdc_pkg.sv
design/hdc_if.sv
design/holiday_date_classifier.sv
tb/tb_top.sv
